[hdl/assert_macros.svh]
// Assertion macros shared by the RTL of the stalk key decoder.
// Depends on nothing; the bodies are empty when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define SKD_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define SKD_NEVER(lbl, clk, rst, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define SKD_ASSERT(lbl, clk, rst, prop, msg)
`define SKD_NEVER(lbl, clk, rst, cond, msg)
`endif
`endif

[hdl/stkd_pkg.sv]
// Types, codes and lookup functions of the stalk key decoder.
// Depends on nothing; used by stkd_engine and the top level.
`default_nettype none
package stkd_pkg;

  typedef struct packed {
    logic       action;
    logic [7:0] pkt_byte0;
    logic [7:0] pkt_byte1;
    logic [7:0] pkt_byte2;
    logic [3:0] screen_mode;
  } item_t;

  typedef struct packed {
    logic [2:0]  host_button;
    logic [15:0] host_time_held;
    logic        frame_valid;
    logic [7:0]  frame_byte0;
    logic [7:0]  frame_byte1;
    logic [7:0]  frame_byte2;
  } result_t;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;

  localparam logic [CFG_INDEX_W-1:0] CFG_PHONE_KIT     = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_KEY_RELEASE   = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_LONG_PRESS    = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_REPEAT        = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_HANGUP_EXTEND = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] CFG_RADIO_MODE    = 3'd5;

  localparam logic ACT_PACKET = 1'b0;
  localparam logic ACT_TICK   = 1'b1;

  localparam logic [2:0] BTN_NONE   = 3'd0;
  localparam logic [2:0] BTN_HANGUP = 3'd1;
  localparam logic [2:0] BTN_VOICE  = 3'd2;
  localparam logic [2:0] BTN_TUP    = 3'd3;
  localparam logic [2:0] BTN_TDN    = 3'd4;
  localparam logic [2:0] BTN_VUP    = 3'd5;
  localparam logic [2:0] BTN_VDN    = 3'd6;

  localparam logic [3:0] MENU_NONE     = 4'd0;
  localparam logic [3:0] MENU_MAIN     = 4'd1;
  localparam logic [3:0] MENU_SETTINGS = 4'd2;
  localparam logic [3:0] MENU_WRIGHT   = 4'd3;
  localparam logic [3:0] MENU_WLEFT    = 4'd4;
  localparam logic [3:0] MENU_LEFT     = 4'd5;
  localparam logic [3:0] MENU_RIGHT    = 4'd6;
  localparam logic [3:0] MENU_BC       = 4'd7;
  localparam logic [3:0] MENU_OK       = 4'd8;

  localparam logic [7:0] PKT_KEY      = 8'h01;
  localparam logic [7:0] PKT_VOLUME   = 8'h08;
  localparam logic [7:0] PKT_VOLUME_ID = 8'h93;
  localparam logic [7:0] PKT_VOL_UP   = 8'h01;
  localparam logic [7:0] PKT_VOL_DOWN = 8'hff;

  localparam logic [7:0] FRAME_RELEASE = 8'h00;
  localparam logic [7:0] FRAME_PRESS   = 8'h01;
  localparam logic [7:0] FRAME_WHEEL   = 8'h08;
  localparam logic [7:0] WHEEL_CODE    = 8'h6a;
  localparam logic [7:0] WHEEL_RIGHT   = 8'h01;
  localparam logic [7:0] WHEEL_LEFT    = 8'hff;

  // Key code of a key press packet; BTN_NONE means the code is unknown.
  function automatic logic [2:0] decode_key(input logic [7:0] code);
    logic [2:0] btn;
    btn = BTN_NONE;
    case (code)
      8'h9f, 8'h82: btn = BTN_HANGUP;
      8'h90, 8'h81: btn = BTN_VOICE;
      8'h91, 8'h8e: btn = BTN_TUP;
      8'h92, 8'h8f: btn = BTN_TDN;
      8'h9d:        btn = BTN_VUP;
      8'h9e:        btn = BTN_VDN;
      default:      btn = BTN_NONE;
    endcase
    return btn;
  endfunction

  function automatic logic [7:0] menu_code(input logic [3:0] key);
    logic [7:0] code;
    code = 8'h00;
    case (key)
      MENU_MAIN:     code = 8'he0;
      MENU_SETTINGS: code = 8'hff;
      MENU_WRIGHT:   code = 8'h6a;
      MENU_WLEFT:    code = 8'h6a;
      MENU_LEFT:     code = 8'h6d;
      MENU_RIGHT:    code = 8'h6c;
      MENU_BC:       code = 8'h01;
      MENU_OK:       code = 8'h6f;
      default:       code = 8'h00;
    endcase
    return code;
  endfunction

endpackage
`default_nettype wire

[hdl/stkd_engine.sv]
// Configuration registers, button state and the single-pass step logic.
// Depends on stkd_pkg; computes the result of the beat offered on take.
`default_nettype none
module stkd_engine
  import stkd_pkg::*;
#(
  parameter int TIMER_BITS = 16
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_write,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                   take,
  input  wire item_t                  item,
  output result_t                     result_next
);

  localparam int CW = (TIMER_BITS > 16) ? TIMER_BITS : 16;
  localparam logic [TIMER_BITS-1:0] TMAX = '1;

  logic        handsfree_fitted;
  logic [15:0] key_release_ticks;
  logic [15:0] long_press_ticks;
  logic [15:0] repeat_ticks;
  logic [15:0] hangup_extend_ticks;
  logic [3:0]  radio_mode_code;

  logic [2:0]            raw_button, raw_button_next;
  logic [TIMER_BITS-1:0] release_timer, release_timer_next;
  logic [2:0]            prev_raw_button, prev_raw_button_next;
  logic [2:0]            released_button, released_button_next;
  logic [TIMER_BITS-1:0] released_hold_time, released_hold_time_next;
  logic [TIMER_BITS-1:0] raw_held_timer, raw_held_timer_next;
  logic [3:0]            menu_key, menu_key_next;
  logic [3:0]            prev_menu_key, prev_menu_key_next;
  logic [TIMER_BITS-1:0] repeat_timer, repeat_timer_next;
  logic [7:0]            repeat_count, repeat_count_next;
  logic [TIMER_BITS-1:0] extend_timer, extend_timer_next;
  logic [3:0]            prev_display_mode, prev_display_mode_next;
  logic                  wait_release, wait_release_next;
  logic [2:0]            host_button, host_button_next;
  logic [2:0]            prev_host_button, prev_host_button_next;
  logic [TIMER_BITS-1:0] host_hold_timer, host_hold_timer_next;

  logic [CW-1:0]         release_wide, repeat_wide, extend_wide, long_wide, hold_wide;
  logic [TIMER_BITS-1:0] release_load, repeat_load, extend_load;
  logic [2:0]            key_btn;
  logic                  long_hold, short_release;
  logic [7:0]            code;
  logic                  frame_valid;
  logic [7:0]            frame0, frame1, frame2;

  assign release_wide = CW'(key_release_ticks);
  assign repeat_wide  = CW'(repeat_ticks);
  assign extend_wide  = CW'(hangup_extend_ticks);
  assign long_wide    = CW'(long_press_ticks);
  assign release_load = release_wide[TIMER_BITS-1:0];
  assign repeat_load  = repeat_wide[TIMER_BITS-1:0];
  assign extend_load  = extend_wide[TIMER_BITS-1:0];
  assign key_btn      = decode_key(item.pkt_byte1);

  always_comb begin
    raw_button_next         = raw_button;
    release_timer_next      = release_timer;
    prev_raw_button_next    = prev_raw_button;
    released_button_next    = released_button;
    released_hold_time_next = released_hold_time;
    raw_held_timer_next     = raw_held_timer;
    menu_key_next           = menu_key;
    prev_menu_key_next      = prev_menu_key;
    repeat_timer_next       = repeat_timer;
    repeat_count_next       = repeat_count;
    extend_timer_next       = extend_timer;
    prev_display_mode_next  = prev_display_mode;
    wait_release_next       = wait_release;
    host_button_next        = host_button;
    prev_host_button_next   = prev_host_button;
    host_hold_timer_next    = host_hold_timer;
    long_hold               = 1'b0;
    short_release           = 1'b0;
    code                    = 8'h00;
    frame_valid             = 1'b0;
    frame0                  = 8'h00;
    frame1                  = 8'h00;
    frame2                  = 8'h00;

    if (item.action == ACT_PACKET) begin
      if (item.pkt_byte0 == PKT_KEY) begin
        if (key_btn != BTN_NONE) begin
          raw_button_next = key_btn;
        end
      end else if (item.pkt_byte0 == PKT_VOLUME && item.pkt_byte1 == PKT_VOLUME_ID) begin
        if (item.pkt_byte2 == PKT_VOL_UP) begin
          raw_button_next    = BTN_VUP;
          release_timer_next = release_load;
        end else if (item.pkt_byte2 == PKT_VOL_DOWN) begin
          raw_button_next    = BTN_VDN;
          release_timer_next = release_load;
        end
      end else begin
        raw_button_next    = BTN_NONE;
        release_timer_next = '0;
      end
    end else begin
      // Release timeout and raw hold time.
      if (release_timer != '0) begin
        release_timer_next = release_timer - 1'b1;
        if (release_timer_next == '0) begin
          raw_button_next = BTN_NONE;
        end
      end
      if (raw_button_next != prev_raw_button) begin
        released_button_next    = prev_raw_button;
        released_hold_time_next = raw_held_timer;
        raw_held_timer_next     = '0;
        prev_raw_button_next    = raw_button_next;
      end else if (raw_held_timer != TMAX) begin
        raw_held_timer_next = raw_held_timer + 1'b1;
      end

      // Mapping by display mode.
      if (item.screen_mode != prev_display_mode) begin
        prev_display_mode_next = item.screen_mode;
        wait_release_next      = 1'b1;
      end
      if (raw_button_next == BTN_NONE) begin
        wait_release_next = 1'b0;
      end
      long_hold     = CW'(raw_held_timer_next) > long_wide;
      short_release = CW'(released_hold_time_next) < long_wide;

      if (item.screen_mode == radio_mode_code) begin
        menu_key_next = MENU_NONE;
        unique case (raw_button_next)
          BTN_HANGUP: begin
            if (long_hold) begin
              menu_key_next = MENU_SETTINGS;
            end
          end
          BTN_VOICE: begin
            if (!wait_release_next && !handsfree_fitted) begin
              host_button_next  = BTN_VOICE;
              extend_timer_next = '0;
            end
          end
          BTN_TUP, BTN_TDN, BTN_VUP, BTN_VDN: begin
            if (!wait_release_next) begin
              host_button_next  = raw_button_next;
              extend_timer_next = '0;
            end
          end
          BTN_NONE: begin
            if (released_button_next == BTN_HANGUP) begin
              if (short_release && !handsfree_fitted) begin
                host_button_next  = BTN_HANGUP;
                extend_timer_next = extend_load;
              end
            end else if (extend_timer != '0) begin
              extend_timer_next = extend_timer - 1'b1;
            end else begin
              host_button_next = BTN_NONE;
            end
          end
          default: host_button_next = BTN_NONE;
        endcase
      end else begin
        host_button_next = BTN_NONE;
        unique case (raw_button_next)
          BTN_HANGUP: begin
            if (long_hold) begin
              menu_key_next = MENU_SETTINGS;
            end
          end
          BTN_TUP: if (!wait_release_next) menu_key_next = MENU_RIGHT;
          BTN_TDN: if (!wait_release_next) menu_key_next = MENU_LEFT;
          BTN_VUP: if (!wait_release_next) menu_key_next = MENU_OK;
          BTN_VDN: if (!wait_release_next) menu_key_next = MENU_MAIN;
          default: menu_key_next = MENU_NONE;
        endcase
      end
      released_button_next = BTN_NONE;

      if (host_hold_timer != TMAX) begin
        host_hold_timer_next = host_hold_timer + 1'b1;
      end
      if (prev_host_button != host_button_next) begin
        host_hold_timer_next  = '0;
        prev_host_button_next = host_button_next;
      end

      // Menu key frames.
      code = menu_code(menu_key_next);
      if (menu_key_next != MENU_NONE) begin
        if (prev_menu_key != menu_key_next) begin
          repeat_timer_next = repeat_load;
          repeat_count_next = 8'h00;
          frame_valid       = 1'b1;
          if (menu_key_next == MENU_WRIGHT) begin
            frame0 = FRAME_WHEEL;
            frame1 = WHEEL_CODE;
            frame2 = WHEEL_RIGHT;
          end else if (menu_key_next == MENU_WLEFT) begin
            frame0 = FRAME_WHEEL;
            frame1 = WHEEL_CODE;
            frame2 = WHEEL_LEFT;
          end else begin
            frame0 = FRAME_PRESS;
            frame1 = code;
            frame2 = 8'h00;
          end
        end else if (repeat_timer != '0) begin
          repeat_timer_next = repeat_timer - 1'b1;
          if (repeat_timer_next == '0) begin
            repeat_timer_next = repeat_load;
            repeat_count_next = repeat_count + 1'b1;
            if (menu_key_next != MENU_WRIGHT && menu_key_next != MENU_WLEFT) begin
              frame_valid = 1'b1;
              frame0      = FRAME_PRESS;
              frame1      = code;
              frame2      = repeat_count_next;
            end
          end
        end
      end else if (prev_menu_key != MENU_NONE) begin
        repeat_timer_next = '0;
        if (prev_menu_key != MENU_WRIGHT && prev_menu_key != MENU_WLEFT) begin
          frame_valid = 1'b1;
          frame0      = FRAME_RELEASE;
          frame1      = menu_code(prev_menu_key);
          frame2      = repeat_count;
        end
        repeat_count_next = 8'h00;
      end
      prev_menu_key_next = menu_key_next;
    end
  end

  assign hold_wide = CW'(host_hold_timer_next);

  always_comb begin
    result_next.host_button    = host_button_next;
    result_next.host_time_held = hold_wide[15:0];
    result_next.frame_valid    = frame_valid;
    result_next.frame_byte0    = frame0;
    result_next.frame_byte1    = frame1;
    result_next.frame_byte2    = frame2;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      handsfree_fitted    <= 1'b0;
      key_release_ticks   <= 16'd50;
      long_press_ticks    <= 16'd2000;
      repeat_ticks        <= 16'd100;
      hangup_extend_ticks <= 16'd200;
      radio_mode_code     <= 4'd0;
      raw_button          <= BTN_NONE;
      release_timer       <= '0;
      prev_raw_button     <= BTN_NONE;
      released_button     <= BTN_NONE;
      released_hold_time  <= '0;
      raw_held_timer      <= '0;
      menu_key            <= MENU_NONE;
      prev_menu_key       <= MENU_NONE;
      repeat_timer        <= '0;
      repeat_count        <= 8'h00;
      extend_timer        <= '0;
      prev_display_mode   <= 4'd0;
      wait_release        <= 1'b0;
      host_button         <= BTN_NONE;
      prev_host_button    <= BTN_NONE;
      host_hold_timer     <= '0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          CFG_PHONE_KIT:     handsfree_fitted    <= cfg_data[0];
          CFG_KEY_RELEASE:   key_release_ticks   <= cfg_data;
          CFG_LONG_PRESS:    long_press_ticks    <= cfg_data;
          CFG_REPEAT:        repeat_ticks        <= cfg_data;
          CFG_HANGUP_EXTEND: hangup_extend_ticks <= cfg_data;
          CFG_RADIO_MODE:    radio_mode_code     <= cfg_data[3:0];
          default: ;
        endcase
      end
      if (take) begin
        raw_button         <= raw_button_next;
        release_timer      <= release_timer_next;
        prev_raw_button    <= prev_raw_button_next;
        released_button    <= released_button_next;
        released_hold_time <= released_hold_time_next;
        raw_held_timer     <= raw_held_timer_next;
        menu_key           <= menu_key_next;
        prev_menu_key      <= prev_menu_key_next;
        repeat_timer       <= repeat_timer_next;
        repeat_count       <= repeat_count_next;
        extend_timer       <= extend_timer_next;
        prev_display_mode  <= prev_display_mode_next;
        wait_release       <= wait_release_next;
        host_button        <= host_button_next;
        prev_host_button   <= prev_host_button_next;
        host_hold_timer    <= host_hold_timer_next;
      end
    end
  end

endmodule
`default_nettype wire

[hdl/stalk_key_decoder_with_autorepeat.sv]
// Top level of the stalk key decoder: step engine plus output register and skid.
// Depends on stkd_pkg, stkd_engine and assert_macros.svh.
//
//   channel  direction  handshake                 payload
//   item     in         item_valid / item_stall   item_t
//   result   out        result_valid / result_stall result_t
//   config   in         cfg_write                 cfg_index, cfg_data
//
// Each beat is computed combinationally from the stored state into the result register.
// One beat can be accepted every cycle while the result side keeps up.
// A stalled result is held in the output register and one more in the skid stage.
// Reset is synchronous; it loads the register defaults and clears all button state.
`default_nettype none
`include "assert_macros.svh"
module stalk_key_decoder_with_autorepeat
  import stkd_pkg::*;
#(
  parameter int TIMER_BITS = 16
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_write,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                   item_valid,
  output logic                        item_stall,
  input  wire item_t                  item,
  output logic                        result_valid,
  input  wire logic                   result_stall,
  output result_t                     result
);

  logic    accept;
  logic    result_take;
  logic    skid_valid;
  result_t skid;
  result_t step_result;

  assign item_stall  = skid_valid;
  assign accept      = item_valid && !item_stall;
  assign result_take = result_valid && !result_stall;

  stkd_engine #(
    .TIMER_BITS(TIMER_BITS)
  ) u_engine (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .take       (accept),
    .item       (item),
    .result_next(step_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_valid   <= 1'b0;
    end else if (!result_valid || result_take) begin
      if (skid_valid) begin
        result_valid <= 1'b1;
        skid_valid   <= 1'b0;
      end else begin
        result_valid <= accept;
      end
    end else if (accept) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!result_valid || result_take) begin
      if (skid_valid) begin
        result <= skid;
      end else if (accept) begin
        result <= step_result;
      end
    end else if (accept) begin
      skid <= step_result;
    end
  end

  `SKD_ASSERT(a_skid_behind_out, clk, rst, skid_valid |-> result_valid, "skid holds a beat while the output is empty")
  `SKD_ASSERT(a_skid_moves_up, clk, rst, (result_take && skid_valid) |=> (result_valid && !skid_valid), "skid beat not moved to output")
  `SKD_ASSERT(a_accept_shows, clk, rst, accept |=> result_valid, "accepted beat did not reach the output")
  `SKD_NEVER(a_host_code, clk, rst, result_valid && (result.host_button > BTN_VDN), "host button code out of range")
  `SKD_ASSERT(a_idle_frame_zero, clk, rst, (result_valid && !result.frame_valid) |-> (result.frame_byte0 == 8'h00 && result.frame_byte1 == 8'h00 && result.frame_byte2 == 8'h00), "frame bytes set without a frame")

endmodule
`default_nettype wire
